>>> src/psq_pkg.sv
// ----------------------------------------------------------------------------
// psq_pkg
// Shared types and codes for the priority stack queue: operation codes,
// status codes and the command word broadcast to every cell.
// ----------------------------------------------------------------------------
`default_nettype none

package psq_pkg;

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   typedef logic [1:0] psq_status_type;

   localparam psq_status_type STATUS_OK        = 2'd0;
   localparam psq_status_type STATUS_POP_EMPTY = 2'd1;
   localparam psq_status_type STATUS_PUSH_FULL = 2'd2;

   typedef struct packed {
      logic push;
      logic pop;
   } psq_cmd_type;

endpackage

`default_nettype wire

>>> src/priority_stack_queue_core.sv
// Latency: a result is presented the cycle after its request transfer.
// Throughput: one operation per cycle while the result side keeps up; all
//   cells compare the pushed priority and shift in the same cycle.
// Reset: synchronous; clears the entry count and the result valid. Slot
//   contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// priority_stack_queue_core
// Bounded priority stack built as a row of cells sorted by descending
// priority; pushes insert ahead of equal priorities, pops remove the head.
// ----------------------------------------------------------------------------
`default_nettype none

module priority_stack_queue_core #(
   parameter int DEPTH      = 16,
   parameter int VALUE_BITS = 16,
   parameter int PRIO_BITS  = 8,
   localparam int CNT_BITS  = $clog2(DEPTH + 1)
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_valid,
   output logic                        req_ready,
   input  wire                         req_operation,
   input  wire  [VALUE_BITS-1:0]       req_item_value,
   input  wire  [PRIO_BITS-1:0]        req_item_priority,
   output logic                        rsp_valid,
   input  wire                         rsp_ready,
   output logic [VALUE_BITS-1:0]       rsp_head_value,
   output logic [PRIO_BITS-1:0]        rsp_head_priority,
   output logic [CNT_BITS-1:0]         rsp_entry_count,
   output logic                        rsp_is_empty,
   output psq_pkg::psq_status_type     rsp_status
);
   import psq_pkg::*;

   logic                  accept;
   logic                  full, empty;
   psq_cmd_type           cmd;
   psq_status_type        status_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [VALUE_BITS-1:0] head_value_ff, head_value_in;
   logic [PRIO_BITS-1:0]  head_prio_ff, head_prio_in;
   logic [CNT_BITS-1:0]   rsp_count_ff;
   logic                  rsp_empty_ff;
   psq_status_type        rsp_status_ff;

   logic                  cell_keep       [DEPTH];
   logic [VALUE_BITS-1:0] cell_value      [DEPTH];
   logic [PRIO_BITS-1:0]  cell_prio       [DEPTH];
   logic [VALUE_BITS-1:0] cell_next_value [DEPTH];
   logic [PRIO_BITS-1:0]  cell_next_prio  [DEPTH];

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign full      = (count_ff == CNT_BITS'(DEPTH));
   assign empty     = (count_ff == '0);

   always_comb begin
      cmd       = '0;
      count_in  = count_ff;
      status_in = STATUS_OK;
      if (accept) begin
         if (req_operation == OP_PUSH) begin
            if (full) begin
               status_in = STATUS_PUSH_FULL;
            end else begin
               cmd.push = 1'b1;
               count_in = count_ff + 1'b1;
            end
         end else begin
            if (empty) begin
               status_in = STATUS_POP_EMPTY;
            end else begin
               cmd.pop  = 1'b1;
               count_in = count_ff - 1'b1;
            end
         end
      end
   end

   genvar i;
   generate
      for (i = 0; i < DEPTH; i++) begin : g_cell
         logic                  left_keep;
         logic [VALUE_BITS-1:0] left_value, right_value;
         logic [PRIO_BITS-1:0]  left_prio, right_prio;

         if (i == 0) begin : g_first
            assign left_keep  = 1'b1;
            assign left_value = '0;
            assign left_prio  = '0;
         end else begin : g_inner
            assign left_keep  = cell_keep[i-1];
            assign left_value = cell_value[i-1];
            assign left_prio  = cell_prio[i-1];
         end

         if (i == DEPTH - 1) begin : g_last
            assign right_value = cell_value[i];
            assign right_prio  = cell_prio[i];
         end else begin : g_body
            assign right_value = cell_value[i+1];
            assign right_prio  = cell_prio[i+1];
         end

         psq_cell #(
            .VALUE_BITS (VALUE_BITS),
            .PRIO_BITS  (PRIO_BITS)
         ) u_cell (
            .clock         (clock),
            .cmd_i         (cmd),
            .occupied_i    (count_ff > CNT_BITS'(i)),
            .new_value_i   (req_item_value),
            .new_prio_i    (req_item_priority),
            .left_keep_i   (left_keep),
            .left_value_i  (left_value),
            .left_prio_i   (left_prio),
            .right_value_i (right_value),
            .right_prio_i  (right_prio),
            .keep_o        (cell_keep[i]),
            .value_o       (cell_value[i]),
            .prio_o        (cell_prio[i]),
            .next_value_o  (cell_next_value[i]),
            .next_prio_o   (cell_next_prio[i])
         );
      end
   endgenerate

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (count_in == '0) begin
         head_value_in = '0;
         head_prio_in  = '0;
      end else begin
         head_value_in = cell_next_value[0];
         head_prio_in  = cell_next_prio[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         head_value_ff <= head_value_in;
         head_prio_ff  <= head_prio_in;
         rsp_count_ff  <= count_in;
         rsp_empty_ff  <= (count_in == '0);
         rsp_status_ff <= status_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_head_value    = head_value_ff;
   assign rsp_head_priority = head_prio_ff;
   assign rsp_entry_count   = rsp_count_ff;
   assign rsp_is_empty      = rsp_empty_ff;
   assign rsp_status        = rsp_status_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(DEPTH))
      else $error("entry count exceeds depth");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      accept && req_operation == OP_PUSH && !full |=> count_ff == $past(count_ff) + 1'b1)
      else $error("push did not grow the store");

   a_pop_empty_holds: assert property (@(posedge clock) disable iff (reset)
      accept && req_operation == OP_POP && empty |=> count_ff == '0 &&
      rsp_status == STATUS_POP_EMPTY)
      else $error("pop on empty changed the store");

   a_result_matches: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid && rsp_entry_count == count_ff)
      else $error("result count does not match store");

   a_empty_head_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_empty |-> rsp_entry_count == '0 && rsp_head_priority == '0)
      else $error("empty result carries a head");

endmodule

`default_nettype wire

>>> src/psq_cell.sv
// ----------------------------------------------------------------------------
// psq_cell
// One slot of the sorted store. Compares the pushed priority against its own
// entry and either holds, takes the new pair, takes its left neighbor's pair
// (shift toward the tail) or takes its right neighbor's pair (shift toward
// the head on pop).
// ----------------------------------------------------------------------------
`default_nettype none

module psq_cell #(
   parameter int VALUE_BITS = 16,
   parameter int PRIO_BITS  = 8
) (
   input  wire                       clock,
   input  psq_pkg::psq_cmd_type      cmd_i,
   input  wire                       occupied_i,
   input  wire  [VALUE_BITS-1:0]     new_value_i,
   input  wire  [PRIO_BITS-1:0]      new_prio_i,
   input  wire                       left_keep_i,
   input  wire  [VALUE_BITS-1:0]     left_value_i,
   input  wire  [PRIO_BITS-1:0]      left_prio_i,
   input  wire  [VALUE_BITS-1:0]     right_value_i,
   input  wire  [PRIO_BITS-1:0]      right_prio_i,
   output logic                      keep_o,
   output logic [VALUE_BITS-1:0]     value_o,
   output logic [PRIO_BITS-1:0]      prio_o,
   output logic [VALUE_BITS-1:0]     next_value_o,
   output logic [PRIO_BITS-1:0]      next_prio_o
);
   import psq_pkg::*;

   logic [VALUE_BITS-1:0] value_ff, value_in;
   logic [PRIO_BITS-1:0]  prio_ff, prio_in;
   logic                  keep;

   assign keep = occupied_i && (new_prio_i < prio_ff);

   always_comb begin
      value_in = value_ff;
      prio_in  = prio_ff;
      if (cmd_i.push && !keep) begin
         if (left_keep_i) begin
            value_in = new_value_i;
            prio_in  = new_prio_i;
         end else begin
            value_in = left_value_i;
            prio_in  = left_prio_i;
         end
      end else if (cmd_i.pop) begin
         value_in = right_value_i;
         prio_in  = right_prio_i;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      prio_ff  <= prio_in;
   end

   assign keep_o       = keep;
   assign value_o      = value_ff;
   assign prio_o       = prio_ff;
   assign next_value_o = value_in;
   assign next_prio_o  = prio_in;

endmodule

`default_nettype wire
